@@ sv/cpf_pkg.sv @@
package cpf_pkg;

    localparam int unsigned BYTE_W           = 8;
    localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h8C;
    localparam logic [BYTE_W-1:0] CRC_INIT   = 8'h00;
    localparam logic [BYTE_W-1:0] START_RESET = 8'd170;
    localparam int unsigned JOB_Q_DEPTH      = 4;

    // Input action codes.
    localparam logic ACT_OPEN    = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    // Step codes of the back end sequencer.
    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_THIRD  = 2'd2;
    localparam logic [1:0] STEP_FOURTH = 2'd3;

    // One unit of work for the back end. For an open, byte_a is the status and
    // byte_b the length; for a payload byte, byte_a is the data.
    typedef struct packed {
        logic              is_open;
        logic              closes;
        logic [BYTE_W-1:0] byte_a;
        logic [BYTE_W-1:0] byte_b;
    } t_job;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              packet_end;
        logic              run_last;
    } t_result;

    // Reflected CRC-8 update, one data byte, least significant bit first.
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] d;
        logic              mix;
        c = crc;
        d = data;
        for (int k = 0; k < BYTE_W; k++) begin
            mix = c[0] ^ d[0];
            c   = c >> 1;
            if (mix) begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

@@ sv/crc8_packet_framer.sv @@
// Packet framer: turns header requests and payload bytes into a framed byte
// stream of start byte, status, length, payload, then a Dallas/Maxim CRC-8.
// Input side is a queue write port: a request is taken when push is high and
// full is low. Action 0 opens a packet, action 1 supplies one payload byte.
// Output side is a queue read port: while empty is low the oldest byte is on
// o_tx_byte, o_packet_end and o_run_last, and pop takes it.
// The user must write the start byte register (i_cfg_we/i_cfg_wdata) only
// while idle; the block itself does not enforce it. A request's first byte
// passes through the job queue, then the single output byte register, which
// sets the throughput: one byte per cycle while jobs wait and the receiver
// pops. The front end keeps taking requests every cycle until the job queue
// fills. A payload byte with no packet open is dropped and yields no bytes.
// When the receiver stalls, the output register holds, the back end stops,
// and the job queue fills until full rises; nothing is lost.
// Synchronous reset empties both queues, closes any packet and restores the
// start byte to 0xAA.
module crc8_packet_framer
    import cpf_pkg::*;
#(
    parameter int unsigned JOB_DEPTH = JOB_Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  logic              i_action,
    input  logic [BYTE_W-1:0] i_packet_status,
    input  logic [BYTE_W-1:0] i_frame_len,
    input  logic [BYTE_W-1:0] i_payload_byte,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_tx_byte,
    output logic              o_packet_end,
    output logic              o_run_last
);

    logic    q_push;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    t_job    q_in;
    t_job    q_out;
    t_result result;

    // Front end: classifies requests and tracks the open packet.
    cpf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_q_full        (q_full),
        .i_action        (i_action),
        .i_packet_status (i_packet_status),
        .i_frame_len     (i_frame_len),
        .i_payload_byte  (i_payload_byte),
        .o_q_push        (q_push),
        .o_q_job         (q_in)
    );

    // Short job queue decoupling the front end from the byte sequencer.
    cpf_job_q #(
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty)
    );

    // Back end: emits bytes one per cycle while the receiver pops, and keeps the running CRC.
    cpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job       (q_out),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign full         = q_full;
    assign o_tx_byte    = result.tx_byte;
    assign o_packet_end = result.packet_end;
    assign o_run_last   = result.run_last;

endmodule

@@ sv/cpf_front.sv @@
module cpf_front
    import cpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_q_full,
    input  logic              i_action,
    input  logic [BYTE_W-1:0] i_packet_status,
    input  logic [BYTE_W-1:0] i_frame_len,
    input  logic [BYTE_W-1:0] i_payload_byte,
    output logic              o_q_push,
    output t_job              o_q_job
);

    logic              r_open;
    logic [BYTE_W-1:0] r_left;
    logic              n_open;
    logic [BYTE_W-1:0] n_left;
    logic              accept;

    assign accept = i_push && !i_q_full;

    // Classify the request and track how many payload bytes the open packet still needs.
    always_comb begin
        n_open   = r_open;
        n_left   = r_left;
        o_q_push = 1'b0;
        o_q_job  = '0;
        if (accept) begin
            unique case (i_action)
                ACT_OPEN: begin
                    o_q_push        = 1'b1;
                    o_q_job.is_open = 1'b1;
                    o_q_job.closes  = (i_frame_len == '0);
                    o_q_job.byte_a  = i_packet_status;
                    o_q_job.byte_b  = i_frame_len;
                    n_open          = (i_frame_len != '0);
                    n_left          = i_frame_len;
                end
                ACT_PAYLOAD: begin
                    if (r_open) begin
                        o_q_push        = 1'b1;
                        o_q_job.is_open = 1'b0;
                        o_q_job.closes  = (r_left == BYTE_W'(1));
                        o_q_job.byte_a  = i_payload_byte;
                        n_left          = r_left - BYTE_W'(1);
                        n_open          = (r_left != BYTE_W'(1));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

    // An open packet always waits for at least one more byte, and a closed one for none.
    a_open_has_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_left != '0))
        else $error("open packet with no bytes left");
    a_closed_no_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_left == '0))
        else $error("closed packet with bytes left");

endmodule

@@ sv/cpf_job_q.sv @@
module cpf_job_q
    import cpf_pkg::*;
#(
    parameter int unsigned DEPTH = JOB_Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("job queue count above depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("job queue pointers disagree with empty count");

endmodule

@@ sv/cpf_back.sv @@
module cpf_back
    import cpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    input  t_job              i_job,
    input  logic              i_job_empty,
    output logic              o_job_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output t_result           o_result
);

    logic [BYTE_W-1:0] r_start;
    logic [BYTE_W-1:0] r_crc;
    logic [1:0]        r_step;
    logic              r_out_valid;
    t_result           r_out;

    logic [1:0]        last_step;
    logic              is_crc;
    logic [BYTE_W-1:0] cur_byte;
    logic              advance;
    logic              at_last;

    always_comb begin
        if (i_job.is_open) begin
            last_step = i_job.closes ? STEP_FOURTH : STEP_THIRD;
            is_crc    = (r_step == STEP_FOURTH);
        end else begin
            last_step = i_job.closes ? STEP_SECOND : STEP_FIRST;
            is_crc    = (r_step == STEP_SECOND);
        end
        cur_byte = r_crc;
        if (!is_crc) begin
            if (i_job.is_open) begin
                unique case (r_step)
                    STEP_FIRST:  cur_byte = r_start;
                    STEP_SECOND: cur_byte = i_job.byte_a;
                    STEP_THIRD:  cur_byte = i_job.byte_b;
                    default:     cur_byte = r_crc;
                endcase
            end else begin
                cur_byte = i_job.byte_a;
            end
        end
    end

    assign at_last   = (r_step == last_step);
    assign advance   = !i_job_empty && (!r_out_valid || i_pop);
    assign o_job_pop = advance && at_last;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RESET;
        end else if (i_cfg_we) begin
            r_start <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_step      <= STEP_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_step      <= at_last ? STEP_FIRST : r_step + 2'd1;
                if (i_job.is_open && (r_step == STEP_FIRST)) begin
                    r_crc <= crc8_update(CRC_INIT, cur_byte);
                end else if (!is_crc) begin
                    r_crc <= crc8_update(r_crc, cur_byte);
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.tx_byte    <= cur_byte;
            r_out.packet_end <= is_crc;
            r_out.run_last   <= at_last;
        end
    end

    // The sequencer never walks past the final byte of the job it is serving.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_empty |-> (r_step <= last_step))
        else $error("step beyond last byte of job");
    // A CRC byte always closes the run of bytes from its request.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.packet_end) |-> r_out.run_last)
        else $error("CRC byte not last of its request");

endmodule
